// ----- sv/assert_macros.svh -----
// Assertion macros used by the tile occupancy map back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clk edge outside reset; clk and rst_n come from the using scope.
`define TOM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tile occupancy map assertion failed");

// Antecedent this cycle implies consequent in the next cycle.
`define TOM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tile occupancy map assertion failed");

`else

`define TOM_ASSERT(name, prop)
`define TOM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- sv/tom_pkg.sv -----
// Types, constants and codes of the tile occupancy map.
package tom_pkg;

  localparam int MAX_SIDE    = 128;
  localparam int COUNT_BITS  = 8;
  localparam int KIND_COUNT  = 3;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE);
  localparam int TILE_COUNT  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_BITS   = $clog2(TILE_COUNT);
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_BITS     = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int MODE_BITS    = 2;
  localparam int COORD_BITS   = 10;
  localparam int KIND_BITS    = 2;
  localparam int WMASK_BITS   = 8;
  localparam int CMP_BITS     = COORD_BITS + 1;

  localparam logic [CFG_BITS-1:0] CFG_SIDE_RESET = CFG_BITS'(128);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 1'b1;

  // input mode codes
  localparam logic [MODE_BITS-1:0] MODE_BLOCK = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd0;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INC,
    OP_DEC
  } op_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic                  in_map;
    op_t                   op;
    logic [KIND_BITS-1:0]  kind;
    logic                  query;
    logic [KIND_COUNT-1:0] wmask;
    logic [ADDR_BITS-1:0]  idx;
  } tom_entry_t;

  typedef struct packed {
    logic [KIND_COUNT-1:0]                 mask;
    logic [KIND_COUNT-1:0][COUNT_BITS-1:0] cnt;
  } tile_word_t;

  typedef struct packed {
    logic       push;
    tom_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_ctl_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW
  } bk_state_t;

endpackage

// ----- sv/tom_if.sv -----
// Valid/ready channels of the tile occupancy map: operation items in, results out.
interface tom_in_if;
  import tom_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [MODE_BITS-1:0]         mode;
  logic signed [COORD_BITS-1:0] tile_x;
  logic signed [COORD_BITS-1:0] tile_y;
  logic [KIND_BITS-1:0]         blocker_kind;
  logic [WMASK_BITS-1:0]        walk_mask;

  modport source (output valid, mode, tile_x, tile_y, blocker_kind, walk_mask, input ready);
  modport sink   (input valid, mode, tile_x, tile_y, blocker_kind, walk_mask, output ready);
endinterface

interface tom_out_if;
  import tom_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  walkable;
  logic                  in_bounds;
  logic [KIND_COUNT-1:0] tile_mask;

  modport source (output valid, walkable, in_bounds, tile_mask, input ready);
  modport sink   (input valid, walkable, in_bounds, tile_mask, output ready);
endinterface

// ----- sv/tom_front.sv -----
// Front end: map size registers, item accept, bounds check and operation classification.
module tom_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tom_in_if.sink                               in_ch,
  input  logic                                 cfg_we,
  input  logic [tom_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tom_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  tom_pkg::front_ctl_t                  ctl,
  output tom_pkg::q_wr_t                       q_wr
);
  import tom_pkg::*;

  logic [CFG_BITS-1:0]  width_r;
  logic [CFG_BITS-1:0]  height_r;
  logic [CMP_BITS-1:0]  w_ext, h_ext, w_eff, h_eff, x_ext, y_ext;
  logic [SIDE_BITS-1:0] x_lo, y_lo;
  logic                 in_map;
  logic                 modify;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_SIDE_RESET;
      height_r <= CFG_SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  width_r  <= cfg_wdata;
        CFG_MAP_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes above the array side act as the full side
  always_comb begin
    w_ext = CMP_BITS'(width_r);
    h_ext = CMP_BITS'(height_r);
    w_eff = (w_ext > CMP_BITS'(MAX_SIDE)) ? CMP_BITS'(MAX_SIDE) : w_ext;
    h_eff = (h_ext > CMP_BITS'(MAX_SIDE)) ? CMP_BITS'(MAX_SIDE) : h_ext;
    x_ext = {1'b0, in_ch.tile_x};
    y_ext = {1'b0, in_ch.tile_y};
    in_map = !in_ch.tile_x[COORD_BITS-1] && !in_ch.tile_y[COORD_BITS-1] &&
             (x_ext < w_eff) && (y_ext < h_eff);
    x_lo = x_ext[SIDE_BITS-1:0];
    y_lo = y_ext[SIDE_BITS-1:0];
    modify = ((in_ch.mode == MODE_BLOCK) || (in_ch.mode == MODE_FREE)) &&
             (in_ch.blocker_kind != KIND_NONE);
  end

  assign in_ch.ready = !ctl.q_full && !ctl.clearing;

  always_comb begin
    q_wr.push         = in_ch.valid && in_ch.ready;
    q_wr.entry.in_map = in_map;
    if (!modify)                       q_wr.entry.op = OP_NOP;
    else if (in_ch.mode == MODE_BLOCK) q_wr.entry.op = OP_INC;
    else                               q_wr.entry.op = OP_DEC;
    q_wr.entry.kind   = in_ch.blocker_kind;
    q_wr.entry.query  = (in_ch.mode == MODE_QUERY);
    q_wr.entry.wmask  = in_ch.walk_mask[KIND_COUNT-1:0];
    q_wr.entry.idx    = ADDR_BITS'(y_lo * MAX_SIDE + x_lo);
  end

endmodule

// ----- sv/tom_fifo.sv -----
// Short queue of classified items between front and back.
module tom_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  tom_pkg::q_wr_t      wr,
  input  logic                pop,
  output tom_pkg::tom_entry_t rd_entry,
  output tom_pkg::q_stat_t    stat
);
  import tom_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  tom_entry_t          slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr.push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)     rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (wr.push && !pop)      count_r <= count_r + CNT_BITS'(1);
      else if (pop && !wr.push) count_r <= count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) slot_r[wr_ptr_r] <= wr.entry;
  end

  assign rd_entry   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ----- sv/tom_back.sv -----
// Back end: tile memory clearing, read-modify-write of counts and mask, result register.
`include "assert_macros.svh"

module tom_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tom_pkg::tom_entry_t q_entry,
  input  tom_pkg::q_stat_t    q_stat,
  output logic                q_pop,
  output logic                clearing,
  tom_out_if.source           out_ch
);
  import tom_pkg::*;

  tile_word_t           mem [TILE_COUNT];
  bk_state_t            state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_addr_r;
  tom_entry_t           item_r;
  tile_word_t           rd_word_r;
  tile_word_t           new_word;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  tile_word_t           mem_wdata;
  logic                 out_load, out_take;
  logic                 out_valid_r, out_walk_r, out_inb_r;
  logic [KIND_COUNT-1:0] out_mask_r;
  logic [KIND_COUNT-1:0] res_mask;
  logic [COUNT_BITS-1:0] cur, nv;

  assign out_take = out_valid_r && out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_addr_r == ADDR_BITS'(TILE_COUNT - 1)) state_nxt = BK_IDLE;
      BK_IDLE:  if (q_pop) state_nxt = BK_RMW;
      BK_RMW:   state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing  = (state_r == BK_CLEAR);
    q_pop     = (state_r == BK_IDLE) && !q_stat.empty && (!out_valid_r || out_take);
    out_load  = (state_r == BK_RMW);
    mem_we    = clearing || ((state_r == BK_RMW) && item_r.in_map && (item_r.op != OP_NOP));
    mem_waddr = clearing ? clr_addr_r : item_r.idx;
    mem_wdata = clearing ? '0 : new_word;
  end

  // count update of the selected kind, saturating
  always_comb begin
    new_word = rd_word_r;
    cur      = '0;
    nv       = '0;
    for (int k = 0; k < KIND_COUNT; k++) begin
      if (item_r.kind == KIND_BITS'(k + 1)) begin
        cur = rd_word_r.cnt[k];
        if (item_r.op == OP_INC) begin
          nv = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
          new_word.cnt[k] = nv;
          if (nv != '0) new_word.mask[k] = 1'b1;
        end else if (item_r.op == OP_DEC) begin
          nv = (cur == CNT_MIN) ? cur : cur - COUNT_BITS'(1);
          new_word.cnt[k] = nv;
          if (nv == '0) new_word.mask[k] = 1'b0;
        end
      end
    end
    res_mask = item_r.in_map ? new_word.mask : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
      if (out_load)      out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_entry;
    if (out_load) begin
      out_inb_r  <= item_r.in_map;
      out_mask_r <= res_mask;
      out_walk_r <= item_r.query && item_r.in_map && ((res_mask & item_r.wmask) == '0);
    end
  end

  // tile memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (q_pop) rd_word_r <= mem[q_entry.idx];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.walkable  = out_walk_r;
  assign out_ch.in_bounds = out_inb_r;
  assign out_ch.tile_mask = out_mask_r;

  `TOM_ASSERT(a_no_pop_clear, (state_r == BK_CLEAR) |-> !q_pop)
  `TOM_ASSERT(a_out_free_rmw, (state_r == BK_RMW) |-> !out_valid_r)
  `TOM_ASSERT_NEXT(a_pop_then_rmw, q_pop, state_r == BK_RMW)
  `TOM_ASSERT(a_oob_quiet, (out_valid_r && !out_inb_r) |-> (out_mask_r == '0 && !out_walk_r))

endmodule

// ----- sv/tile_occupancy_map.sv -----
// Tile occupancy map: per tile, saturating signed counts of walls, characters and monsters
// with a three-bit blocked mask, updated by block and free items and read by walk queries.
// Every item gives one result. The back end pops an item when idle, reading its tile word;
// in its read-modify-write state it writes the updated word and loads the result register.
// It pops again only when idle with the result register free or being taken, and a two-entry
// queue lets the front keep accepting meanwhile. After reset a clearing pass zeroes all
// MAX_SIDE*MAX_SIDE tiles (16384 at the default size), one tile per cycle, with in_ch.ready low
// throughout; configuration writes are taken at any time and keep the stored tiles.
module tile_occupancy_map (
  input  logic                             clk,
  input  logic                             rst_n,
  tom_in_if.sink                           in_ch,
  tom_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tom_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tom_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import tom_pkg::*;

  q_wr_t      q_wr;
  tom_entry_t q_entry;
  q_stat_t    q_stat;
  logic       q_pop;
  logic       clearing;
  front_ctl_t front_ctl;

  always_comb begin
    front_ctl.q_full   = q_stat.full;
    front_ctl.clearing = clearing;
  end

  tom_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (front_ctl),
    .q_wr      (q_wr)
  );

  tom_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .pop      (q_pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  tom_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_entry  (q_entry),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

// ----- test/tom_checker.sv -----
// Checker for the tile occupancy map: tracks tile counts and masks, compares every result item.
module tom_checker
  import tom_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  tom_in_if                       in_mon,
  tom_out_if                      out_mon,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  output int                      mismatch_count,
  output int                      pending_results
);

  typedef struct packed {
    logic                  walkable;
    logic                  in_bounds;
    logic [KIND_COUNT-1:0] tile_mask;
  } occ_result_t;

  logic [COUNT_BITS-1:0] tally [KIND_COUNT][TILE_COUNT];
  logic [KIND_COUNT-1:0] blocked [TILE_COUNT];
  logic [CFG_BITS-1:0]   width_reg;
  logic [CFG_BITS-1:0]   height_reg;

  occ_result_t expected_q [$];
  int          errors;
  int          results_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // applies one operation item to the tracked map and returns the result it must give
  function automatic occ_result_t apply_item(input logic [MODE_BITS-1:0]         mode,
                                             input logic signed [COORD_BITS-1:0] tx,
                                             input logic signed [COORD_BITS-1:0] ty,
                                             input logic [KIND_BITS-1:0]         kind,
                                             input logic [WMASK_BITS-1:0]        wmask);
    occ_result_t           res;
    int                    col;
    int                    row;
    int                    cols;
    int                    rows;
    int                    slot;
    int                    k;
    logic [COUNT_BITS-1:0] cnt;
    logic [KIND_COUNT-1:0] bit_sel;
    res  = '0;
    col  = tx;
    row  = ty;
    cols = (width_reg > MAX_SIDE) ? MAX_SIDE : int'(width_reg);
    rows = (height_reg > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
    if (col >= 0 && row >= 0 && col < cols && row < rows) begin
      slot = row * MAX_SIDE + col;
      if ((mode == MODE_BLOCK || mode == MODE_FREE) && kind != KIND_NONE) begin
        k       = int'(kind) - 1;
        cnt     = tally[k][slot];
        bit_sel = KIND_COUNT'(1) << k;
        if (mode == MODE_BLOCK) begin
          if (cnt != CNT_MAX) cnt = cnt + 1'b1;
          if (cnt != '0) blocked[slot] = blocked[slot] | bit_sel;
        end else begin
          if (cnt != CNT_MIN) cnt = cnt - 1'b1;
          if (cnt == '0) blocked[slot] = blocked[slot] & ~bit_sel;
        end
        tally[k][slot] = cnt;
      end
      res.in_bounds = 1'b1;
      res.tile_mask = blocked[slot];
      if (mode == MODE_QUERY)
        res.walkable = ((blocked[slot] & wmask[KIND_COUNT-1:0]) == '0);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    occ_result_t got;
    occ_result_t want;
    if (!rst_n) begin
      for (int t = 0; t < TILE_COUNT; t++) begin
        blocked[t] = '0;
        for (int k = 0; k < KIND_COUNT; k++) tally[k][t] = '0;
      end
      width_reg  = CFG_SIDE_RESET;
      height_reg = CFG_SIDE_RESET;
      expected_q.delete();
    end else begin
      // results first: a result can never belong to an item taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got = '{walkable: out_mon.walkable, in_bounds: out_mon.in_bounds,
                tile_mask: out_mon.tile_mask};
        if (expected_q.size() == 0) begin
          report_mismatch("item with nothing pending", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.walkable !== want.walkable)
            report_mismatch("walkable", got.walkable, want.walkable);
          if (got.in_bounds !== want.in_bounds)
            report_mismatch("in_bounds", got.in_bounds, want.in_bounds);
          if (got.tile_mask !== want.tile_mask)
            report_mismatch("tile_mask", got.tile_mask, want.tile_mask);
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.insert(expected_q.size(),
                          apply_item(in_mon.mode, in_mon.tile_x, in_mon.tile_y,
                                     in_mon.blocker_kind, in_mon.walk_mask));
      // a size written on this edge applies to items taken after it
      if (cfg_we) begin
        if (cfg_index == CFG_MAP_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == CFG_MAP_HEIGHT) height_reg = cfg_wdata;
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the tile occupancy map testbench: clock, reset, stimulus, map sizes and verdict.
module tb_top;
  import tom_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_WALL    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CHAR    = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_MONSTER = 2'd3;
  localparam logic [MODE_BITS-1:0] MODE_SPARE   = 2'd3;
  localparam int                   DRAIN_CYCLES = 20;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  int mismatch_count;
  int pending_results;
  int send_idle   = 0;
  int recv_idle   = 0;
  int items_sent  = 0;
  int cur_w       = 128;
  int cur_h       = 128;

  tom_in_if  in_ch ();
  tom_out_if out_ch ();

  tile_occupancy_map u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tom_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random stalls with occasional stretches of ready held high
  initial begin
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) begin
        out_ch.ready <= 1'b1;
        calm--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
        if ($urandom_range(39) == 0) calm = $urandom_range(24, 8);
      end
    end
  end

  task automatic send_op(input logic [MODE_BITS-1:0]  mode,
                         input int                    x,
                         input int                    y,
                         input logic [KIND_BITS-1:0]  kind,
                         input logic [WMASK_BITS-1:0] wmask);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.tile_x       <= x[COORD_BITS-1:0];
    in_ch.tile_y       <= y[COORD_BITS-1:0];
    in_ch.blocker_kind <= kind;
    in_ch.walk_mask    <= wmask;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold the sender until every result item has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_map_size(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_wdata <= w[CFG_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_wdata <= h[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 3)
      0: begin send_idle = 36; recv_idle = 70; end
      1: begin send_idle = 70; recv_idle = 36; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
  endtask

  // mostly a few hot tiles, some map edges, some anywhere in the coordinate range
  function automatic int pick_coord(input int side);
    int                           r;
    int                           lim;
    logic signed [COORD_BITS-1:0] raw;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(3);
    if (r < 75) begin
      lim = (side > MAX_SIDE) ? MAX_SIDE : side;
      return lim - 1 + $urandom_range(1);
    end
    if (r < 88) return $urandom_range(MAX_SIDE - 1);
    raw = COORD_BITS'($urandom);
    return raw;
  endfunction

  task automatic run_mix(input int n);
    int                   target;
    int                   x;
    int                   y;
    int                   reps;
    logic [KIND_BITS-1:0] kind;
    target = items_sent + n;
    while (items_sent < target) begin
      x    = pick_coord(cur_w);
      y    = pick_coord(cur_h);
      kind = KIND_BITS'($urandom_range(3, 1));
      if ($urandom_range(99) < 60) begin
        // occupy, look, release (sometimes too often), look again
        reps = $urandom_range(4, 1);
        repeat (reps) send_op(MODE_BLOCK, x, y, kind, WMASK_BITS'($urandom));
        send_op(MODE_QUERY, x, y, KIND_BITS'($urandom), WMASK_BITS'($urandom));
        repeat ($urandom_range(reps + 1))
          send_op(MODE_FREE, x, y, kind, WMASK_BITS'($urandom));
        send_op(MODE_QUERY, x, y, KIND_BITS'($urandom), WMASK_BITS'($urandom));
      end else begin
        send_op(MODE_BITS'($urandom), x, y, KIND_BITS'($urandom), WMASK_BITS'($urandom));
      end
      if ($urandom_range(99) == 0) wait_drain();
    end
  endtask

  initial begin
    logic [KIND_BITS-1:0] sat_kind;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_BLOCK;
    in_ch.tile_x       <= '0;
    in_ch.tile_y       <= '0;
    in_ch.blocker_kind <= KIND_NONE;
    in_ch.walk_mask    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on the reset-size map
    set_idling(0);
    send_op(MODE_QUERY, 0, 0, KIND_NONE, 8'hff);
    send_op(MODE_BLOCK, 0, 0, KIND_WALL, 8'h00);
    send_op(MODE_QUERY, 0, 0, KIND_NONE, 8'h01);
    send_op(MODE_QUERY, 0, 0, KIND_WALL, 8'hfe);
    send_op(MODE_BLOCK, 0, 0, KIND_CHAR, 8'h55);
    send_op(MODE_BLOCK, 0, 0, KIND_MONSTER, 8'haa);
    send_op(MODE_FREE, 0, 0, KIND_WALL, 8'h00);
    send_op(MODE_BLOCK, 0, 0, KIND_NONE, 8'h00);
    send_op(MODE_FREE, 0, 0, KIND_NONE, 8'h00);
    send_op(MODE_SPARE, 0, 0, KIND_WALL, 8'h00);
    send_op(MODE_QUERY, 0, 0, KIND_NONE, 8'h04);
    // free below zero, then a block back to zero: mask bit stays clear
    send_op(MODE_FREE, 5, 5, KIND_MONSTER, 8'h00);
    send_op(MODE_BLOCK, 5, 5, KIND_MONSTER, 8'h00);
    send_op(MODE_BLOCK, 5, 5, KIND_MONSTER, 8'h00);
    send_op(MODE_BLOCK, 127, 127, KIND_WALL, 8'hff);
    send_op(MODE_QUERY, 127, 127, KIND_NONE, 8'h06);
    send_op(MODE_BLOCK, 128, 0, KIND_WALL, 8'h00);
    send_op(MODE_BLOCK, 0, 128, KIND_CHAR, 8'h00);
    send_op(MODE_FREE, -1, 0, KIND_WALL, 8'h00);
    send_op(MODE_QUERY, 0, -1, KIND_NONE, 8'h00);
    send_op(MODE_BLOCK, -512, -512, KIND_MONSTER, 8'h80);
    send_op(MODE_QUERY, 511, 511, KIND_NONE, 8'h00);
    send_op(MODE_QUERY, -512, 511, KIND_NONE, 8'h7f);

    run_mix(30);

    // oversized map, one count driven into its upper limit
    wait_drain();
    set_map_size(255, 255);
    set_idling(1);
    sat_kind = KIND_BITS'($urandom_range(3, 1));
    repeat (130) send_op(MODE_BLOCK, 1, 2, sat_kind, WMASK_BITS'($urandom));
    send_op(MODE_QUERY, 1, 2, KIND_NONE, WMASK_BITS'($urandom));
    run_mix(20);

    wait_drain();
    set_map_size(1, 1);
    set_idling(2);
    run_mix(30);

    // empty maps: nothing is in bounds
    wait_drain();
    set_map_size(0, 6);
    set_idling(0);
    run_mix(20);

    wait_drain();
    set_map_size(5, 0);
    run_mix(10);

    // a count driven into its lower limit
    wait_drain();
    set_map_size(128, 3);
    set_idling(1);
    sat_kind = KIND_BITS'($urandom_range(3, 1));
    repeat (132) send_op(MODE_FREE, 3, 2, sat_kind, WMASK_BITS'($urandom));
    send_op(MODE_QUERY, 3, 2, KIND_NONE, WMASK_BITS'($urandom));
    run_mix(30);

    wait_drain();
    set_map_size($urandom_range(128, 1), $urandom_range(128, 1));
    set_idling(2);
    run_mix(20);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #3200000;
    $display("FAILURE");
    $finish;
  end

endmodule
